// File: rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and mixing functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned LenStart   = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	localparam logic [31:0] K_TAB [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t sel;
		logic      count_inc;
		logic      init_work;
		logic      round_en;
		logic [5:0] rnd;
		logic [2:0] len_idx;
		logic      fold;
		logic      restart;
		logic [2:0] word_idx;
	} cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sm_s0(input logic [31:0] x);
		sm_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sm_s1(input logic [31:0] x);
		sm_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sha_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// valid-ready channels for message items and digest items
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	modport source (output valid, kind, data_byte, input ready);
	modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;
	modport source (output valid, digest_word, word_index, last, input ready);
	modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sha_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_datapath
// block shift register, message schedule, round unit, hash state, bit count
// ----------------------------------------------------------------------------
module sha_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_pkg::cmd_t cmd,
	input  wire logic [7:0]    data_byte,
	output logic [31:0]        digest_word
);
	import sha_pkg::*;

	logic [511:0] block_q;
	logic [31:0]  work_q [8];
	logic [31:0]  hash_q [8];
	logic [63:0]  count_q;

	logic [7:0]  byte_in;
	logic [5:0]  len_sh;
	logic [31:0] w_new, t1, t2;

	always_comb begin
		len_sh = {3'd7 - cmd.len_idx, 3'b000};
		case (cmd.sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = PadByte;
			SEL_LEN:  byte_in = 8'(count_q >> len_sh);
			default:  byte_in = 8'h00;
		endcase
	end

	// schedule word for the round after the current window
	assign w_new = sm_s1(block_q[63:32]) + block_q[223:192] + sm_s0(block_q[479:448])
		+ block_q[511:480];

	assign t1 = work_q[7] + big_s1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ K_TAB[cmd.rnd] + block_q[511:480];
	assign t2 = big_s0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			block_q <= {block_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			block_q <= {block_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			work_q <= hash_q;
		end else if (cmd.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= IV_TAB;
			count_q <= '0;
		end else begin
			if (cmd.restart) begin
				hash_q  <= IV_TAB;
				count_q <= '0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
				end
				if (cmd.count_inc) count_q <= count_q + 64'd8;
			end
		end
	end

	assign digest_word = hash_q[cmd.word_idx];

endmodule
`default_nettype wire

// File: rtl/core/sha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer for byte gathering, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_kind,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output sha_pkg::cmd_t cmd
);
	import sha_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] fill_q, rnd_q;
	logic [2:0] word_q;
	logic       fin_q, wrap_q, last_blk_q;
	logic       in_fire, out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && fill_q == 6'd63) state_d = ST_ROUND;
				else if (in_fire && in_kind) state_d = ST_PAD;
			end
			ST_ROUND: begin
				if (rnd_q == 6'(Rounds - 1)) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (last_blk_q) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_PAD: begin
				if (fill_q == 6'd63) state_d = ST_ROUND;
			end
			ST_EMIT: begin
				if (out_fire && word_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.sel      = SEL_ZERO;
		cmd.rnd      = rnd_q;
		cmd.len_idx  = fill_q[2:0];
		cmd.word_idx = word_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.shift_en  = in_fire;
				cmd.sel       = in_kind ? SEL_PAD : SEL_DATA;
				cmd.count_inc = in_fire && !in_kind;
				cmd.init_work = in_fire && fill_q == 6'd63;
			end
			ST_ROUND: cmd.round_en = 1'b1;
			ST_FOLD:  cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.shift_en  = 1'b1;
				cmd.sel       = (!wrap_q && fill_q >= 6'(LenStart)) ? SEL_LEN : SEL_ZERO;
				cmd.init_work = (fill_q == 6'd63);
			end
			ST_EMIT: cmd.restart = out_fire && word_q == 3'd7;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			rnd_q      <= '0;
			word_q     <= '0;
			fin_q      <= 1'b0;
			wrap_q     <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.shift_en) fill_q <= fill_q + 6'd1;
			if (cmd.round_en) rnd_q <= rnd_q + 6'd1;
			if (out_fire) word_q <= word_q + 3'd1;
			if (state_q == ST_IDLE && in_fire) begin
				fin_q      <= in_kind;
				// 0x80 leaves no room for the length: an extra block follows
				wrap_q     <= in_kind && fill_q >= 6'(LenStart) && fill_q != 6'd63;
				last_blk_q <= 1'b0;
			end
			if (state_q == ST_PAD && fill_q == 6'd63) begin
				wrap_q     <= 1'b0;
				last_blk_q <= !wrap_q;
			end
		end
	end

	property p_round_run;
		@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q != 6'd63 |=> state_q == ST_ROUND;
	endproperty
	a_round_run: assert property (p_round_run) else $error("round run cut short");

	property p_emit_aligned;
		@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> fill_q == 6'd0 && rnd_q == 6'd0;
	endproperty
	a_emit_aligned: assert property (p_emit_aligned) else $error("digest out of block sync");

	property p_fold_after_rounds;
		@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> $past(state_q) == ST_ROUND && $past(rnd_q) == 6'd63;
	endproperty
	a_fold_after_rounds: assert property (p_fold_after_rounds) else $error("fold without rounds");

endmodule
`default_nettype wire

// File: rtl/core/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, eight digest words per finish item
// ----------------------------------------------------------------------------
// message byte: shifted in when taken; the 64th byte of a block starts the 64 rounds, then the fold
// finish item: padding bytes shifted one per cycle, then the rounds and the fold for each block
// (one or two blocks), then eight digest items, one per cycle when taken
// no byte is taken while a block's rounds and fold run on the single shared round unit
// reset: hash state to the initial values, bit count zero, controller idle
module sha256_byte_stream_hasher (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    msg,
	sha_out_if.source digest
);
	import sha_pkg::*;

	cmd_t cmd;

	// controller: byte fill, padding sequence, round count, word index
	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_kind   (msg.kind),
		.in_ready  (msg.ready),
		.out_valid (digest.valid),
		.out_ready (digest.ready),
		.cmd       (cmd)
	);

	// datapath: block window, round registers, hash words, bit count
	sha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.digest_word (digest.digest_word)
	);

	// word index and last flag follow the controller's output counter
	assign digest.word_index = cmd.word_idx;
	assign digest.last       = (cmd.word_idx == 3'd7);

endmodule
`default_nettype wire
